// ----- src/kbd_pkg.sv -----
// ----------------------------------------------------------------------------
// kbd_pkg: shared types and constants for the bicycle derivative block
// Fixed-point formats, CORDIC arctangent table and pipeline beat types.
// ----------------------------------------------------------------------------
package kbd_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int STAGE_W       = $clog2(ATAN_ENTRIES);

  localparam int ANG_W      = 34;
  localparam int ROT_W      = 32;
  localparam int PROD_W     = 49;
  localparam int SP_W       = 48;
  localparam int NUM_W      = 64;
  localparam int Q_W        = 18;
  localparam int FRAC_SHIFT = 30;
  localparam int DEN_SHIFT  = 12;

  typedef logic signed [14:0] heading_t;
  typedef logic signed [15:0] speed_t;
  typedef logic signed [13:0] steer_t;
  typedef logic signed [15:0] rate_t;
  typedef logic [15:0]        inv_wb_t;

  localparam inv_wb_t INV_WB_RESET = 16'd26214;
  localparam rate_t   SAT_POS      = 16'sh7FFF;
  localparam rate_t   SAT_NEG      = 16'sh8000;

  localparam logic signed [ROT_W-1:0]  CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [ANG_W-1:0]  PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [PROD_W:0]   ROUND_Q30   = (PROD_W+1)'(64'd1 << (FRAC_SHIFT-1));

  localparam logic signed [ROT_W-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6, 32'sh03FEAB76,
    32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55, 32'sh003FFFEA, 32'sh001FFFFD,
    32'sh000FFFFF, 32'sh0007FFFF, 32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF,
    32'sh00007FFF, 32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
  };

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } kbd_rot_t;

  typedef struct packed {
    logic              valid;
    kbd_rot_t          hrot;
    kbd_rot_t          srot;
    logic signed [16:0] speed_h;
    speed_t            speed;
    rate_t             accel;
    rate_t             steer_rate;
  } kbd_cord_t;

  typedef struct packed {
    logic                     valid;
    logic signed [PROD_W-1:0] xp;
    logic signed [PROD_W-1:0] yp;
    logic signed [SP_W-1:0]   sp;
    logic signed [ROT_W-1:0]  cs;
    rate_t                    accel;
    rate_t                    steer_rate;
  } kbd_m1_t;

  typedef struct packed {
    logic                    valid;
    logic signed [NUM_W-1:0] num;
    logic signed [ROT_W-1:0] cs;
    rate_t                   x_rate;
    rate_t                   y_rate;
    rate_t                   accel;
    rate_t                   steer_rate;
  } kbd_m2_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] an;
    logic [NUM_W-1:0] ad;
    logic             negq;
    logic             zero;
    rate_t            x_rate;
    rate_t            y_rate;
    rate_t            accel;
    rate_t            steer_rate;
  } kbd_m3_t;

  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] dsh;
    logic [Q_W-1:0]   quo;
    logic             negq;
    logic             zero;
    rate_t            x_rate;
    rate_t            y_rate;
    rate_t            accel;
    rate_t            steer_rate;
  } kbd_div_t;

  typedef struct packed {
    rate_t x_rate;
    rate_t y_rate;
    rate_t yaw_rate;
    rate_t speed_rate;
    rate_t steer_rate;
    logic  yaw_saturated;
  } kbd_res_t;

endpackage

// ----- src/kbd_ifs.sv -----
// ----------------------------------------------------------------------------
// kbd channel interfaces
// Valid/ready channels for samples, derivatives and the wheelbase register.
// ----------------------------------------------------------------------------
interface kbd_sample_if;
  import kbd_pkg::*;
  logic     valid;
  logic     ready;
  heading_t heading;
  speed_t   speed;
  steer_t   steer_angle;
  rate_t    accel;
  rate_t    steer_rate_cmd;
  modport source (output valid, heading, speed, steer_angle, accel, steer_rate_cmd,
                  input ready);
  modport sink (input valid, heading, speed, steer_angle, accel, steer_rate_cmd,
                output ready);
endinterface

interface kbd_deriv_if;
  import kbd_pkg::*;
  logic  valid;
  logic  ready;
  rate_t x_rate;
  rate_t y_rate;
  rate_t yaw_rate;
  rate_t speed_rate;
  rate_t steer_rate;
  logic  yaw_saturated;
  modport source (output valid, x_rate, y_rate, yaw_rate, speed_rate, steer_rate,
                  yaw_saturated, input ready);
  modport sink (input valid, x_rate, y_rate, yaw_rate, speed_rate, steer_rate,
                yaw_saturated, output ready);
endinterface

interface kbd_cfg_if;
  import kbd_pkg::*;
  logic    valid;
  logic    ready;
  inv_wb_t inv_wheelbase;
  modport source (output valid, inv_wheelbase, input ready);
  modport sink (input valid, inv_wheelbase, output ready);
endinterface

// ----- src/kinematic_bicycle_derivative.sv -----
// ----------------------------------------------------------------------------
// kinematic_bicycle_derivative: kinematic single-track vehicle derivative
// Pipelined evaluation of x, y and yaw rates for one state/control sample.
//
// Channels: sample (heading, speed, steer_angle, accel, steer_rate_cmd) in,
// deriv (x_rate, y_rate, yaw_rate, speed_rate, steer_rate, yaw_saturated)
// out, cfg writes inv_wheelbase (Q0.16 reciprocal wheelbase) and is always
// ready. Write cfg only while no sample is in flight.
// Throughput: one sample per cycle while the skid entry is empty. Between the
// sample beat and the deriv beat lie the input register, the chain of CORDIC
// cells, four multiply/sign stages, a chain of 18 divider cells that forms
// the tangent quotient one bit per cell, and the output register.
// Reset: pipeline empties, inv_wheelbase returns to 26214 (2.5 m).
// Stall: an output register plus one skid entry absorb a stalled receiver;
// sample.ready drops only once the skid entry is full, and the whole
// pipeline then holds until deriv takes a beat.
// ----------------------------------------------------------------------------
module kinematic_bicycle_derivative (
  input logic        clk,
  input logic        rst,
  kbd_sample_if.sink sample,
  kbd_deriv_if.source deriv,
  kbd_cfg_if.sink    cfg
);
  import kbd_pkg::*;

  inv_wb_t   inv_wb;
  logic      adv;
  kbd_cord_t cord [CORDIC_STAGES+1];
  kbd_cord_t cord0_next;
  kbd_m1_t   m1, m1_next;
  kbd_m2_t   m2, m2_next;
  kbd_m3_t   m3, m3_next;
  kbd_div_t  div [Q_W+1];
  kbd_div_t  div0_next;
  kbd_res_t  tail_res;
  logic      out_valid;
  kbd_res_t  out_res;
  logic      skid_valid;
  kbd_res_t  skid_res;

  function automatic logic [ROT_W:0] reduce(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    logic                    neg;
    r   = a;
    neg = 1'b0;
    if (a > HALF_PI_Q30) begin
      r   = a - PI_Q30;
      neg = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      r   = a + PI_Q30;
      neg = 1'b1;
    end
    return {neg, r[ROT_W-1:0]};
  endfunction

  function automatic rate_t round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0]            t;
    logic signed [PROD_W-FRAC_SHIFT:0] q;
    t = $signed({p[PROD_W-1], p}) + ROUND_Q30;
    q = t[PROD_W:FRAC_SHIFT];
    if (q > $signed(SAT_POS)) begin
      return SAT_POS;
    end else if (q < $signed(SAT_NEG)) begin
      return SAT_NEG;
    end
    return rate_t'(q[15:0]);
  endfunction

  // Configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_wb <= INV_WB_RESET;
    end else if (cfg.valid) begin
      inv_wb <= cfg.inv_wheelbase;
    end
  end

  assign adv          = !skid_valid;
  assign sample.ready = adv;

  // Angle reduction
  always_comb begin
    logic [ROT_W:0]     hred;
    logic [ROT_W:0]     sred;
    logic signed [16:0] vext;
    hred = reduce($signed({sample.heading[14], sample.heading, 18'b0}));
    sred = reduce($signed({{2{sample.steer_angle[13]}}, sample.steer_angle, 18'b0}));
    vext = $signed({sample.speed[15], sample.speed});
    cord0_next.valid      = sample.valid;
    cord0_next.hrot.x     = CORDIC_GAIN;
    cord0_next.hrot.y     = '0;
    cord0_next.hrot.z     = $signed(hred[ROT_W-1:0]);
    cord0_next.srot.x     = CORDIC_GAIN;
    cord0_next.srot.y     = '0;
    cord0_next.srot.z     = $signed(sred[ROT_W-1:0]);
    cord0_next.speed_h    = hred[ROT_W] ? -vext : vext;
    cord0_next.speed      = sample.speed;
    cord0_next.accel      = sample.accel;
    cord0_next.steer_rate = sample.steer_rate_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cord[0].valid <= 1'b0;
    end else if (adv) begin
      cord[0] <= cord0_next;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    kbd_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .stage (STAGE_W'(i)),
      .din   (cord[i]),
      .dout  (cord[i+1])
    );
  end

  // Products
  always_comb begin
    m1_next.valid      = cord[CORDIC_STAGES].valid;
    m1_next.xp         = $signed(cord[CORDIC_STAGES].speed_h)
                         * $signed(cord[CORDIC_STAGES].hrot.x);
    m1_next.yp         = $signed(cord[CORDIC_STAGES].speed_h)
                         * $signed(cord[CORDIC_STAGES].hrot.y);
    m1_next.sp         = $signed(cord[CORDIC_STAGES].speed)
                         * $signed(cord[CORDIC_STAGES].srot.y);
    m1_next.cs         = cord[CORDIC_STAGES].srot.x;
    m1_next.accel      = cord[CORDIC_STAGES].accel;
    m1_next.steer_rate = cord[CORDIC_STAGES].steer_rate;
  end

  always_comb begin
    logic signed [NUM_W:0] nprod;
    nprod              = $signed(m1.sp) * $signed({1'b0, inv_wb});
    m2_next.valid      = m1.valid;
    m2_next.num        = $signed(nprod[NUM_W-1:0]);
    m2_next.cs         = m1.cs;
    m2_next.x_rate     = round_sat(m1.xp);
    m2_next.y_rate     = round_sat(m1.yp);
    m2_next.accel      = m1.accel;
    m2_next.steer_rate = m1.steer_rate;
  end

  // Magnitudes and quotient sign
  always_comb begin
    logic [ROT_W-1:0] cs_mag;
    cs_mag             = m2.cs[ROT_W-1] ? ROT_W'(-m2.cs) : ROT_W'(m2.cs);
    m3_next.valid      = m2.valid;
    m3_next.an         = m2.num[NUM_W-1] ? NUM_W'(-m2.num) : NUM_W'(m2.num);
    m3_next.ad         = NUM_W'(cs_mag) << DEN_SHIFT;
    m3_next.negq       = m2.num[NUM_W-1] ^ m2.cs[ROT_W-1];
    m3_next.zero       = (m2.num == '0);
    m3_next.x_rate     = m2.x_rate;
    m3_next.y_rate     = m2.y_rate;
    m3_next.accel      = m2.accel;
    m3_next.steer_rate = m2.steer_rate;
  end

  always_comb begin
    div0_next.valid      = m3.valid;
    div0_next.rem        = m3.an + (m3.ad >> 1);
    div0_next.dsh        = m3.ad << (Q_W - 1);
    div0_next.quo        = '0;
    div0_next.negq       = m3.negq;
    div0_next.zero       = m3.zero;
    div0_next.x_rate     = m3.x_rate;
    div0_next.y_rate     = m3.y_rate;
    div0_next.accel      = m3.accel;
    div0_next.steer_rate = m3.steer_rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1.valid     <= 1'b0;
      m2.valid     <= 1'b0;
      m3.valid     <= 1'b0;
      div[0].valid <= 1'b0;
    end else if (adv) begin
      m1     <= m1_next;
      m2     <= m2_next;
      m3     <= m3_next;
      div[0] <= div0_next;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    kbd_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (div[k]),
      .dout (div[k+1])
    );
  end

  // Yaw rate rounding result and saturation
  always_comb begin
    logic [Q_W-2:0] q;
    q                      = div[Q_W].quo[Q_W-2:0];
    tail_res.x_rate        = div[Q_W].x_rate;
    tail_res.y_rate        = div[Q_W].y_rate;
    tail_res.speed_rate    = div[Q_W].accel;
    tail_res.steer_rate    = div[Q_W].steer_rate;
    tail_res.yaw_rate      = '0;
    tail_res.yaw_saturated = 1'b0;
    if (div[Q_W].zero) begin
      tail_res.yaw_rate = '0;
    end else if (div[Q_W].quo[Q_W-1]) begin
      tail_res.yaw_rate      = div[Q_W].negq ? SAT_NEG : SAT_POS;
      tail_res.yaw_saturated = 1'b1;
    end else if (!div[Q_W].negq) begin
      if (q > (Q_W-1)'(SAT_POS)) begin
        tail_res.yaw_rate      = SAT_POS;
        tail_res.yaw_saturated = 1'b1;
      end else begin
        tail_res.yaw_rate = $signed(q[15:0]);
      end
    end else begin
      if (q > (Q_W-1)'(unsigned'(SAT_NEG))) begin
        tail_res.yaw_rate      = SAT_NEG;
        tail_res.yaw_saturated = 1'b1;
      end else begin
        tail_res.yaw_rate = rate_t'(q[15:0] ^ 16'hFFFF) + rate_t'(1);
      end
    end
  end

  // Output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || deriv.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= div[Q_W].valid;
      end
    end else if (div[Q_W].valid && adv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || deriv.ready) begin
      out_res <= skid_valid ? skid_res : tail_res;
    end
    if (adv) begin
      skid_res <= tail_res;
    end
  end

  assign deriv.valid         = out_valid;
  assign deriv.x_rate        = out_res.x_rate;
  assign deriv.y_rate        = out_res.y_rate;
  assign deriv.yaw_rate      = out_res.yaw_rate;
  assign deriv.speed_rate    = out_res.speed_rate;
  assign deriv.steer_rate    = out_res.steer_rate;
  assign deriv.yaw_saturated = out_res.yaw_saturated;

endmodule

// ----- src/kbd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// kbd_cordic_cell: one CORDIC rotation step for heading and steer angles
// Rotates both vectors by one table angle and forwards the beat.
// ----------------------------------------------------------------------------
module kbd_cordic_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [kbd_pkg::STAGE_W-1:0] stage,
  input  kbd_pkg::kbd_cord_t       din,
  output kbd_pkg::kbd_cord_t       dout
);
  import kbd_pkg::*;

  kbd_cord_t dout_next;

  function automatic kbd_rot_t rotate(input kbd_rot_t r, input logic [STAGE_W-1:0] s);
    kbd_rot_t                o;
    logic signed [ROT_W-1:0] xs;
    logic signed [ROT_W-1:0] ys;
    xs = $signed(r.x) >>> s;
    ys = $signed(r.y) >>> s;
    if (!r.z[ROT_W-1]) begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.z = r.z - ATAN_Q30[s];
    end else begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.z = r.z + ATAN_Q30[s];
    end
    return o;
  endfunction

  always_comb begin
    dout_next      = din;
    dout_next.hrot = rotate(din.hrot, stage);
    dout_next.srot = rotate(din.srot, stage);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

// ----- src/kbd_div_cell.sv -----
// ----------------------------------------------------------------------------
// kbd_div_cell: one restoring division step
// Develops one quotient bit and halves the shifted divisor.
// ----------------------------------------------------------------------------
module kbd_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  kbd_pkg::kbd_div_t din,
  output kbd_pkg::kbd_div_t dout
);
  import kbd_pkg::*;

  kbd_div_t dout_next;

  always_comb begin
    dout_next = din;
    if (din.rem >= din.dsh) begin
      dout_next.rem = din.rem - din.dsh;
      dout_next.quo = {din.quo[Q_W-2:0], 1'b1};
    end else begin
      dout_next.quo = {din.quo[Q_W-2:0], 1'b0};
    end
    dout_next.dsh = din.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= dout_next;
    end
  end

endmodule

// ----- verif/kinematic_bicycle_derivative_tb.sv -----
// ----------------------------------------------------------------------------
// kinematic_bicycle_derivative_tb: self-checking bench for the bicycle derivative
// Drives samples over valid/ready with random gaps and output stalls, predicts
// every derivative beat with a bit-exact CORDIC/divider model and compares
// each field. Walks the wheelbase register through its extremes and random
// settings between drained phases.
// ----------------------------------------------------------------------------
module kinematic_bicycle_derivative_tb;
  import kbd_pkg::*;

  localparam int     CYCLE_LIMIT     = 400000;
  localparam int     GAP_MAX         = 13;
  localparam int     TRIG_ENTRIES    = 24;
  localparam longint GAIN_Q30        = 64'sd652032874;
  localparam longint PI_RAD_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_RAD_Q30 = 64'sd1686629713;
  localparam longint HALF_LSB_Q30    = 64'sd536870912;
  localparam longint ATAN_TBL [TRIG_ENTRIES] = '{
    64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6, 64'sh03FEAB76,
    64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55, 64'sh003FFFEA, 64'sh001FFFFD,
    64'sh000FFFFF, 64'sh0007FFFF, 64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF,
    64'sh00007FFF, 64'sh00003FFF, 64'sh00001FFF, 64'sh00000FFF, 64'sh000007FF,
    64'sh000003FF, 64'sh000001FF, 64'sh000000FF, 64'sh0000007F
  };

  logic clk;
  logic rst;

  kbd_sample_if sample_ch ();
  kbd_deriv_if  deriv_ch ();
  kbd_cfg_if    cfg_ch ();

  kinematic_bicycle_derivative dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .deriv  (deriv_ch),
    .cfg    (cfg_ch)
  );

  kbd_res_t expected_q [$];
  kbd_res_t want_beat;
  inv_wb_t  inv_wb_model;
  int       tx_gap_max;
  int       rx_gap_max;
  int       rx_hold_req;
  int       cycles;
  int       errors;
  int       samples_sent;
  int       beats_checked;
  int       sat_expected;
  int       cfg_writes;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic void cordic_sincos(input longint ang_q12, output longint cos_q30,
                                        output longint sin_q30);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    z    = ang_q12 * 64'sd262144;
    x    = GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    if (z > HALF_PI_RAD_Q30) begin
      z    = z - PI_RAD_Q30;
      flip = 1'b1;
    end else if (z < -HALF_PI_RAD_Q30) begin
      z    = z + PI_RAD_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES && i < TRIG_ENTRIES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TBL[i];
      end
      x = nx;
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  function automatic longint clamp16(input longint val, output bit hit);
    hit = 1'b0;
    if (val > 32767) begin
      hit = 1'b1;
      return 32767;
    end
    if (val < -32768) begin
      hit = 1'b1;
      return -32768;
    end
    return val;
  endfunction

  function automatic kbd_res_t derive_rates(input heading_t hd, input speed_t spd,
                                            input steer_t st, input rate_t acc,
                                            input rate_t srt, input inv_wb_t iwb);
    longint          hc, hs, sc, ss, xr, yr, yaw, num, den;
    longint unsigned an, ad, q;
    bit              unused, clip, neg;
    kbd_res_t        res;
    cordic_sincos(longint'(hd), hc, hs);
    xr = clamp16((longint'(spd) * hc + HALF_LSB_Q30) >>> 30, unused);
    yr = clamp16((longint'(spd) * hs + HALF_LSB_Q30) >>> 30, unused);
    cordic_sincos(longint'(st), sc, ss);
    num  = longint'(spd) * ss * longint'(iwb);
    den  = sc * 64'sd4096;
    clip = 1'b0;
    if (num == 0) begin
      yaw = 0;
    end else if (den == 0) begin
      clip = 1'b1;
      yaw  = (num > 0) ? 32767 : -32768;
    end else begin
      neg = (num < 0) != (den < 0);
      an  = (num < 0) ? -num : num;
      ad  = (den < 0) ? -den : den;
      q   = (an + ad / 2) / ad;
      yaw = clamp16(neg ? -longint'(q) : longint'(q), clip);
    end
    res.x_rate        = xr[15:0];
    res.y_rate        = yr[15:0];
    res.yaw_rate      = yaw[15:0];
    res.speed_rate    = acc;
    res.steer_rate    = srt;
    res.yaw_saturated = clip;
    return res;
  endfunction

  task automatic send_sample(input heading_t hd, input speed_t spd, input steer_t st,
                             input rate_t acc, input rate_t srt);
    int       gap;
    kbd_res_t want;
    gap = $urandom_range(tx_gap_max);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid          <= 1'b1;
    sample_ch.heading        <= hd;
    sample_ch.speed          <= spd;
    sample_ch.steer_angle    <= st;
    sample_ch.accel          <= acc;
    sample_ch.steer_rate_cmd <= srt;
    do @(posedge clk); while (!sample_ch.ready);
    want = derive_rates(hd, spd, st, acc, srt, inv_wb_model);
    expected_q.push_back(want);
    samples_sent++;
    if (want.yaw_saturated) sat_expected++;
  endtask

  task automatic send_random_sample();
    heading_t hd;
    speed_t   spd;
    steer_t   st;
    rate_t    acc;
    rate_t    srt;
    int       sel;
    int       mag;
    sel = $urandom_range(99);
    if (sel < 15) begin
      mag = ($urandom_range(1) ? 6434 : 12865) - 3 + int'($urandom_range(6));
      hd  = heading_t'($urandom_range(1) ? -mag : mag);
    end else begin
      hd = heading_t'(int'($urandom_range(25736)) - 12868);
    end
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(4))
        0:       spd = 16'sh7FFF;
        1:       spd = 16'sh8000;
        2:       spd = 16'sd0;
        3:       spd = 16'sd1;
        default: spd = -16'sd1;
      endcase
    end else if (sel < 25) begin
      spd = speed_t'(int'($urandom_range(4096)) - 2048);
    end else begin
      spd = speed_t'($urandom_range(65535));
    end
    sel = $urandom_range(99);
    if (sel < 10) begin
      mag = 5734 - int'($urandom_range(3));
      st  = steer_t'($urandom_range(1) ? -mag : mag);
    end else if (sel < 15) begin
      st = '0;
    end else begin
      st = steer_t'(int'($urandom_range(11468)) - 5734);
    end
    acc = rate_t'($urandom_range(65535));
    srt = rate_t'($urandom_range(65535));
    send_sample(hd, spd, st, acc, srt);
  endtask

  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_inv_wheelbase(input inv_wb_t value);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.inv_wheelbase <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    inv_wb_model = value;
    cfg_writes++;
  endtask

  task automatic test_directed_extremes();
    send_sample(15'sd0, 16'sd0, 14'sd0, 16'sd0, 16'sd0);
    send_sample(15'sd12868, 16'sh7FFF, 14'sd5734, 16'sh7FFF, 16'sh7FFF);
    send_sample(-15'sd12868, 16'sh8000, -14'sd5734, 16'sh8000, 16'sh8000);
    send_sample(15'sd6433, 16'sh7FFF, 14'sd0, 16'sd1, -16'sd1);
    send_sample(15'sd6434, 16'sh8000, 14'sd0, -16'sd1, 16'sd1);
    send_sample(-15'sd6433, 16'sh7FFF, 14'sd100, 16'sh5555, 16'shAAAA);
    send_sample(-15'sd6434, 16'sh8000, -14'sd100, 16'shAAAA, 16'sh5555);
    send_sample(15'sd3217, 16'sd0, 14'sd5734, 16'sd256, 16'sd4096);
    send_sample(15'sd0, 16'sh7FFF, 14'sd0, 16'sd0, 16'sd0);
    send_sample(-15'sd3217, 16'sh7FFF, 14'sd5734, 16'sd0, 16'sd0);
    send_sample(15'sd9650, 16'sh7FFF, -14'sd5734, 16'sd0, 16'sd0);
    send_sample(15'sd1000, 16'sd256, 14'sd410, 16'sd0, 16'sd0);
    send_sample(-15'sd1, -16'sd1, -14'sd1, 16'sd0, 16'sd0);
    send_sample(15'sd1, 16'sd1, 14'sd1, 16'sd0, 16'sd0);
  endtask

  task automatic test_wheelbase_extremes();
    inv_wb_t settings [4];
    settings = '{16'd65535, 16'd1, 16'd0, INV_WB_RESET};
    foreach (settings[k]) begin
      wait_drained();
      write_inv_wheelbase(settings[k]);
      send_sample(15'sd500, 16'sh7FFF, 14'sd5734, 16'sd0, 16'sd0);
      send_sample(-15'sd500, 16'sh8000, 14'sd5734, 16'sd0, 16'sd0);
      send_sample(15'sd0, 16'sd300, -14'sd200, 16'sd0, 16'sd0);
    end
  endtask

  task automatic test_random_phases();
    inv_wb_t iwb;
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      case ($urandom_range(3))
        0:       iwb = inv_wb_t'($urandom_range(255, 1));
        1:       iwb = inv_wb_t'($urandom_range(65535, 60000));
        2:       iwb = inv_wb_t'($urandom_range(32768, 16384));
        default: iwb = inv_wb_t'($urandom_range(65535, 1));
      endcase
      write_inv_wheelbase(iwb);
      for (int n = 0; n < 220; n++) begin
        if (n % 40 == 0) begin
          tx_gap_max = ($urandom_range(3) == 0) ? 0 : GAP_MAX;
          rx_gap_max = ($urandom_range(3) == 0) ? 0 : GAP_MAX;
        end
        send_random_sample();
      end
    end
    tx_gap_max = GAP_MAX;
    rx_gap_max = GAP_MAX;
  endtask

  task automatic test_output_stall();
    wait_drained();
    tx_gap_max  = 0;
    rx_hold_req = 300;
    repeat (120) send_random_sample();
    tx_gap_max = GAP_MAX;
  endtask

  task automatic test_drain_pause();
    repeat (40) send_random_sample();
    wait_drained();
    repeat (40) send_random_sample();
  endtask

  initial begin : deriv_receiver
    int n;
    deriv_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        n           = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        n = $urandom_range(rx_gap_max);
      end
      if (n > 0) begin
        deriv_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      deriv_ch.ready <= 1'b1;
      do @(posedge clk); while (!deriv_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && deriv_ch.valid && deriv_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("derivative beat with no sample outstanding");
        errors++;
      end else begin
        want_beat = expected_q.pop_front();
        beats_checked++;
        if (deriv_ch.x_rate !== want_beat.x_rate) begin
          $error("x_rate: expected %0d, got %0d", want_beat.x_rate, deriv_ch.x_rate);
          errors++;
        end
        if (deriv_ch.y_rate !== want_beat.y_rate) begin
          $error("y_rate: expected %0d, got %0d", want_beat.y_rate, deriv_ch.y_rate);
          errors++;
        end
        if (deriv_ch.yaw_rate !== want_beat.yaw_rate) begin
          $error("yaw_rate: expected %0d, got %0d", want_beat.yaw_rate, deriv_ch.yaw_rate);
          errors++;
        end
        if (deriv_ch.speed_rate !== want_beat.speed_rate) begin
          $error("speed_rate: expected %0d, got %0d", want_beat.speed_rate,
                 deriv_ch.speed_rate);
          errors++;
        end
        if (deriv_ch.steer_rate !== want_beat.steer_rate) begin
          $error("steer_rate: expected %0d, got %0d", want_beat.steer_rate,
                 deriv_ch.steer_rate);
          errors++;
        end
        if (deriv_ch.yaw_saturated !== want_beat.yaw_saturated) begin
          $error("yaw_saturated: expected %0b, got %0b", want_beat.yaw_saturated,
                 deriv_ch.yaw_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles,
               expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    tx_gap_max   = GAP_MAX;
    rx_gap_max   = GAP_MAX;
    rx_hold_req  = 0;
    cycles       = 0;
    errors       = 0;
    samples_sent = 0;
    beats_checked = 0;
    sat_expected = 0;
    cfg_writes   = 0;
    inv_wb_model = INV_WB_RESET;
    rst                      <= 1'b1;
    sample_ch.valid          <= 1'b0;
    sample_ch.heading        <= '0;
    sample_ch.speed          <= '0;
    sample_ch.steer_angle    <= '0;
    sample_ch.accel          <= '0;
    sample_ch.steer_rate_cmd <= '0;
    cfg_ch.valid             <= 1'b0;
    cfg_ch.inv_wheelbase     <= INV_WB_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_wheelbase_extremes();
    test_random_phases();
    test_output_stall();
    test_drain_pause();

    wait_drained();
    repeat (60) @(posedge clk);

    $display("%0d samples sent, %0d derivative beats checked, %0d with yaw clipped",
             samples_sent, beats_checked, sat_expected);
    $display("%0d wheelbase writes incl. 0, 1 and 65535; long output stall and drain pause",
             cfg_writes);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
